// ===== sv/ipc3_pkg.sv =====
// Package for the 3x3 isolated pixel cleaner.
// Holds sizes, counter widths, codes and the stage payload type.
// No dependencies.
package ipc3_pkg;

  localparam int MAX_COLS = 1024;
  localparam int MAX_ROWS = 1024;

  localparam int PIX_W = 8;
  localparam int CFG_W = 11;
  localparam int COL_W = $clog2(MAX_COLS);
  localparam int CNT_W = COL_W + 1;
  localparam int ROW_W = $clog2(MAX_ROWS) + 1;
  localparam int TOT_W = CNT_W + ROW_W;

  localparam logic [CFG_W-1:0] WIDTH_RESET  = CFG_W'(1024);
  localparam logic [CFG_W-1:0] HEIGHT_RESET = CFG_W'(1024);

  localparam logic OP_PIXEL = 1'b0;
  localparam logic OP_DRAIN = 1'b1;

  localparam logic REG_WIDTH  = 1'b0;
  localparam logic REG_HEIGHT = 1'b1;

  typedef enum logic [1:0] {
    SRC_WIN,
    SRC_CENTRE,
    SRC_PREV,
    SRC_PREV2
  } src_t;

  typedef struct packed {
    logic             wr;
    logic             emit;
    logic [COL_W-1:0] addr;
    logic [PIX_W-1:0] pix;
    src_t             src;
    logic             interior;
    logic             last;
    logic             fwd;
    logic [PIX_W-1:0] fwd_prev;
    logic [PIX_W-1:0] fwd_prev2;
  } s1_t;

endpackage

// ===== sv/isolated_pixel_clean_3x3.sv =====
// Top level of the 3x3 isolated pixel cleaner.
// Two line stores, a window and the raster counters; uses ipc3_pkg.
//
// Usage:
//   Input channel (in_valid / in_stall): opcode OP_PIXEL carries one mask pixel
//   in raster order, OP_DRAIN flushes one pending pixel once a full frame is in.
//   Pixel items beyond a full frame and drain items before one are taken and
//   give no result.
//   Output channel (out_valid / out_stall): one cleaned pixel per result item,
//   frame_end set on the last pixel of the image.
//   Config channel (cfg_valid / cfg_ready): cfg_index selects image_width or
//   image_height, cfg_data the 11-bit value; cfg_ready is always high.
//   Throughput: one item per cycle while in_stall is low. Each item reads both
//   line stores at one address; the read data is registered with the item
//   into the store stage, where the window update, cleaning and write-back
//   take place, and the result is registered from there onto out_valid.
//   A pixel leaves one row plus one pixel after it arrives; the last row and
//   pixel come out on drain items.
//   Reset: counters and window clear, both sizes return to 1024. The line
//   stores are not cleared and need no clearing pass.
//   Stall: while out_stall holds a result, the next result waits in the
//   store stage and in_stall rises only once that stage is full too.
module isolated_pixel_clean_3x3 import ipc3_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_stall,
  input  logic             opcode,
  input  logic [PIX_W-1:0] pixel_in,
  output logic             out_valid,
  input  logic             out_stall,
  output logic [PIX_W-1:0] pixel_out,
  output logic             frame_end,
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic             cfg_index,
  input  logic [CFG_W-1:0] cfg_data
);

  logic [CFG_W-1:0] image_width;
  logic [CFG_W-1:0] image_height;

  logic [CNT_W-1:0] in_col, in_col_next;
  logic [ROW_W-1:0] in_row, in_row_next;
  logic [CNT_W-1:0] out_col, out_col_next;
  logic [TOT_W-1:0] out_row, out_row_next;
  logic [TOT_W-1:0] emitted_count, emitted_count_next;

  logic [PIX_W-1:0] mem_prev  [MAX_COLS];
  logic [PIX_W-1:0] mem_prev2 [MAX_COLS];
  logic [PIX_W-1:0] rd_prev, rd_prev2;
  logic [COL_W-1:0] rd_addr;

  logic [PIX_W-1:0] win [3][2];

  s1_t  s1, s1_next;
  logic s1_vld, s1_go, act;
  logic in_accept;

  logic [CNT_W-1:0] w_eff;
  logic [ROW_W-1:0] h_eff;
  logic [TOT_W-1:0] total;
  logic             last_c, interior_c, pix_live, drn_live, adv;
  logic [PIX_W-1:0] p1_eff, p2_eff, emit_val;
  logic             alone;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width  <= WIDTH_RESET;
      image_height <= HEIGHT_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_WIDTH:  image_width  <= cfg_data;
        REG_HEIGHT: image_height <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    if (image_width == '0) begin
      w_eff = CNT_W'(1);
    end else if (int'(image_width) > MAX_COLS) begin
      w_eff = CNT_W'(MAX_COLS);
    end else begin
      w_eff = CNT_W'(image_width);
    end
    if (image_height == '0) begin
      h_eff = ROW_W'(1);
    end else if (int'(image_height) > MAX_ROWS) begin
      h_eff = ROW_W'(MAX_ROWS);
    end else begin
      h_eff = ROW_W'(image_height);
    end
  end

  assign total  = TOT_W'(w_eff) * TOT_W'(h_eff);
  assign last_c = ((TOT_W+1)'(emitted_count) + (TOT_W+1)'(1)) >= (TOT_W+1)'(total);
  assign interior_c = (out_row != '0) && ((out_row + TOT_W'(1)) < TOT_W'(h_eff)) &&
                      (out_col != '0) && ((out_col + CNT_W'(1)) < w_eff);

  assign pix_live = (opcode == OP_PIXEL) && (in_row < h_eff);
  assign drn_live = (opcode == OP_DRAIN) && (in_row >= h_eff);

  assign s1_go     = s1_vld && (!s1.emit || !out_valid || !out_stall);
  assign in_stall  = s1_vld && !s1_go;
  assign in_accept = in_valid && !in_stall;
  assign rd_addr   = (opcode == OP_DRAIN) ? out_col[COL_W-1:0] : in_col[COL_W-1:0];

  assign p1_eff = s1.fwd ? s1.fwd_prev  : rd_prev;
  assign p2_eff = s1.fwd ? s1.fwd_prev2 : rd_prev2;

  always_comb begin
    in_col_next        = in_col;
    in_row_next        = in_row;
    out_col_next       = out_col;
    out_row_next       = out_row;
    emitted_count_next = emitted_count;
    act                = 1'b0;
    adv                = 1'b0;
    s1_next            = '0;
    s1_next.src        = SRC_WIN;
    s1_next.fwd        = s1_go && s1.wr && (s1.addr == rd_addr);
    s1_next.fwd_prev   = s1.pix;
    s1_next.fwd_prev2  = p1_eff;
    if (in_accept && pix_live) begin
      act          = 1'b1;
      s1_next.wr   = 1'b1;
      s1_next.addr = in_col[COL_W-1:0];
      s1_next.pix  = pixel_in;
      if (in_col == '0 && in_row >= ROW_W'(2)) begin
        s1_next.emit = 1'b1;
        s1_next.src  = SRC_WIN;
        adv          = 1'b1;
      end else if (in_col != '0 && in_row != '0) begin
        s1_next.emit     = 1'b1;
        s1_next.src      = SRC_CENTRE;
        s1_next.interior = interior_c;
        adv              = 1'b1;
      end
      if ((in_col + CNT_W'(1)) >= w_eff) begin
        in_col_next = '0;
        in_row_next = in_row + ROW_W'(1);
      end else begin
        in_col_next = in_col + CNT_W'(1);
      end
    end else if (in_accept && drn_live) begin
      act          = 1'b1;
      adv          = 1'b1;
      s1_next.emit = 1'b1;
      s1_next.last = last_c;
      s1_next.src  = ((out_row + TOT_W'(1)) >= TOT_W'(h_eff)) ? SRC_PREV : SRC_PREV2;
    end
    if (adv) begin
      emitted_count_next = emitted_count + TOT_W'(1);
      if ((out_col + CNT_W'(1)) >= w_eff) begin
        out_col_next = '0;
        out_row_next = out_row + TOT_W'(1);
      end else begin
        out_col_next = out_col + CNT_W'(1);
      end
    end
    if (in_accept && drn_live && last_c) begin
      in_col_next        = '0;
      in_row_next        = '0;
      out_col_next       = '0;
      out_row_next       = '0;
      emitted_count_next = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_col        <= '0;
      in_row        <= '0;
      out_col       <= '0;
      out_row       <= '0;
      emitted_count <= '0;
      s1_vld        <= 1'b0;
    end else begin
      in_col        <= in_col_next;
      in_row        <= in_row_next;
      out_col       <= out_col_next;
      out_row       <= out_row_next;
      emitted_count <= emitted_count_next;
      if (in_accept) begin
        s1_vld <= act;
      end else if (s1_go) begin
        s1_vld <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1       <= s1_next;
      rd_prev  <= mem_prev[rd_addr];
      rd_prev2 <= mem_prev2[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (s1_go && s1.wr) begin
      mem_prev[s1.addr]  <= s1.pix;
      mem_prev2[s1.addr] <= p1_eff;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int r = 0; r < 3; r++) begin
        win[r][0] <= '0;
        win[r][1] <= '0;
      end
    end else if (s1_go && s1.wr) begin
      for (int r = 0; r < 3; r++) begin
        win[r][0] <= win[r][1];
      end
      win[0][1] <= p2_eff;
      win[1][1] <= p1_eff;
      win[2][1] <= s1.pix;
    end
  end

  assign alone = (win[0][0] == '0) && (win[0][1] == '0) && (p2_eff == '0) &&
                 (win[1][0] == '0) && (p1_eff == '0) &&
                 (win[2][0] == '0) && (win[2][1] == '0) && (s1.pix == '0);

  always_comb begin
    case (s1.src)
      SRC_WIN:    emit_val = win[1][1];
      SRC_CENTRE: emit_val = (s1.interior && alone) ? '0 : win[1][1];
      SRC_PREV:   emit_val = p1_eff;
      SRC_PREV2:  emit_val = p2_eff;
      default:    emit_val = win[1][1];
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_go && s1.emit) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_go && s1.emit) begin
      pixel_out <= emit_val;
      frame_end <= s1.last;
    end
  end

  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> s1_vld && s1.emit && out_valid && out_stall)
    else $error("input held without a blocked result");

  a_last_from_drain: assert property (@(posedge clk) disable iff (rst)
    s1_vld && s1.last |-> (s1.src == SRC_PREV || s1.src == SRC_PREV2) && !s1.wr)
    else $error("frame end on a non-drain item");

  a_frame_restart: assert property (@(posedge clk) disable iff (rst)
    in_accept && drn_live && last_c |=> in_row == '0 && in_col == '0 && emitted_count == '0)
    else $error("counters not cleared after frame end");

  a_result_lands: assert property (@(posedge clk) disable iff (rst)
    s1_go && s1.emit |=> out_valid)
    else $error("result lost between store stage and output");

endmodule
